// File: rtl/stream_substring_replace_macros.svh
// Assertion macros shared by the checker of the find-and-replace stream block
`ifndef STREAM_SUBSTRING_REPLACE_MACROS_SVH
`define STREAM_SUBSTRING_REPLACE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent
`define SSR_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define SSR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/ssr_pkg.sv
// Types, constants and helper functions of the find-and-replace stream block
package ssr_pkg;

  localparam int unsigned MAX_LEN     = 8;
  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned WORD_W      = 64;
  localparam int unsigned LEN_W       = 4;
  localparam int unsigned BUF_W       = MAX_LEN * BYTE_W;
  localparam int unsigned IDX_W       = $clog2(MAX_LEN);
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned QUEUE_DEPTH = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_BYTES     = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LEN       = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_REPLACEMENT_BYTES = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_REPLACEMENT_LEN   = CFG_IDX_W'(3);

  localparam logic [LEN_W-1:0] MAX_LEN_L = LEN_W'(MAX_LEN);

  typedef enum logic {
    OP_LITERAL = 1'b0,
    OP_REPLACE = 1'b1
  } op_kind_e;

  typedef struct packed {
    logic [BYTE_W-1:0] in_byte;
    logic              end_of_stream;
  } in_item_t;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              last_of_run;
    logic              stream_done;
  } out_item_t;

  typedef struct packed {
    op_kind_e          kind;
    logic [BYTE_W-1:0] value;
    logic              last;
    logic              done;
  } op_t;

  typedef struct packed {
    logic [WORD_W-1:0] pattern_bytes;
    logic [LEN_W-1:0]  pattern_len;
    logic [WORD_W-1:0] replacement_bytes;
    logic [LEN_W-1:0]  replacement_len;
  } cfg_t;

  function automatic logic [LEN_W-1:0] clamp_len(logic [LEN_W-1:0] len);
    return (len > MAX_LEN_L) ? MAX_LEN_L : len;
  endfunction

  // True when the first min(cnt, plen) held bytes equal the pattern prefix
  function automatic logic prefix_hit(logic [BUF_W-1:0]  data_v,
                                      logic [LEN_W-1:0]  cnt,
                                      logic [WORD_W-1:0] pat,
                                      logic [LEN_W-1:0]  plen);
    logic hit;
    hit = 1'b1;
    for (int i = 0; i < MAX_LEN; i++) begin
      if ((LEN_W'(i) < cnt) && (LEN_W'(i) < plen) &&
          (data_v[BYTE_W*i +: BYTE_W] != pat[BYTE_W*i +: BYTE_W])) begin
        hit = 1'b0;
      end
    end
    return hit;
  endfunction

endpackage

// File: rtl/ssr_front.sv
// Front end: takes input bytes, holds the partial match and classifies each step
module ssr_front import ssr_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  cfg_t     cfg_i,
  input  logic     cfg_clear_i,
  input  logic     in_valid_i,
  input  in_item_t in_data_i,
  output logic     in_ready_o,
  output logic     push_o,
  output op_t      push_op_o,
  input  logic     queue_full_i
);

  typedef enum logic [2:0] {
    FE_IDLE  = 3'b001,
    FE_SCAN  = 3'b010,
    FE_FLUSH = 3'b100
  } fe_state_e;

  fe_state_e        state_q, state_d;
  logic [BUF_W-1:0] data_q, data_d;
  logic [LEN_W-1:0] cnt_q, cnt_d;
  logic             eos_q, eos_d;

  logic [LEN_W-1:0] cnt_m1;
  logic [LEN_W-1:0] cnt_base;
  logic             head_hit;
  logic             head_full;
  logic             next_hit;
  logic             lit_go;
  logic             lit_last;
  fe_state_e        lit_next;
  op_t              op;

  assign cnt_m1    = cnt_q - LEN_W'(1);
  assign cnt_base  = cfg_clear_i ? '0 : cnt_q;
  assign head_hit  = prefix_hit(data_q, cnt_q, cfg_i.pattern_bytes, cfg_i.pattern_len);
  assign head_full = head_hit && (cnt_q >= cfg_i.pattern_len);
  assign next_hit  = prefix_hit(data_q >> BYTE_W, cnt_m1, cfg_i.pattern_bytes,
                                cfg_i.pattern_len) && (cnt_m1 < cfg_i.pattern_len);

  always_comb begin
    state_d  = state_q;
    data_d   = data_q;
    cnt_d    = cnt_q;
    eos_d    = eos_q;
    push_o   = 1'b0;
    lit_go   = 1'b0;
    lit_last = (cnt_q == LEN_W'(1));
    lit_next = state_q;
    op.kind  = OP_LITERAL;
    op.value = data_q[BYTE_W-1:0];
    op.last  = 1'b0;
    op.done  = 1'b0;
    case (state_q)
      FE_IDLE: begin
        cnt_d = cnt_base;
        if (in_valid_i) begin
          for (int i = 0; i < MAX_LEN; i++) begin
            if (cnt_base == LEN_W'(i)) begin
              data_d[BYTE_W*i +: BYTE_W] = in_data_i.in_byte;
            end
          end
          cnt_d   = cnt_base + LEN_W'(1);
          eos_d   = in_data_i.end_of_stream;
          state_d = FE_SCAN;
        end
      end
      FE_SCAN: begin
        if (cfg_i.pattern_len == '0) begin
          lit_go   = 1'b1;
          lit_next = FE_SCAN;
        end else if (head_full) begin
          op.kind = OP_REPLACE;
          op.last = (cnt_q == cfg_i.pattern_len);
          op.done = eos_q && (cnt_q == cfg_i.pattern_len);
          if (!queue_full_i) begin
            push_o = 1'b1;
            data_d = data_q >> {cfg_i.pattern_len, 3'b000};
            cnt_d  = cnt_q - cfg_i.pattern_len;
            if (cnt_q == cfg_i.pattern_len) begin
              state_d = FE_IDLE;
            end
          end
        end else if (head_hit) begin
          if (eos_q) begin
            lit_go   = 1'b1;
            lit_next = FE_FLUSH;
          end else begin
            state_d = FE_IDLE;
          end
        end else begin
          lit_go   = 1'b1;
          lit_last = (cnt_q == LEN_W'(1)) || (!eos_q && next_hit);
          lit_next = FE_SCAN;
        end
      end
      FE_FLUSH: begin
        lit_go   = 1'b1;
        lit_next = FE_FLUSH;
      end
      default: begin
        state_d = FE_IDLE;
      end
    endcase

    if (lit_go) begin
      op.last = lit_last;
      op.done = eos_q && lit_last;
      if (!queue_full_i) begin
        push_o = 1'b1;
        data_d = data_q >> BYTE_W;
        cnt_d  = cnt_m1;
        state_d = (cnt_q == LEN_W'(1)) ? FE_IDLE : lit_next;
      end
    end
  end

  assign push_op_o  = op;
  assign in_ready_o = (state_q == FE_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FE_IDLE;
      cnt_q   <= '0;
      eos_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      eos_q   <= eos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

endmodule

// File: rtl/ssr_queue.sv
// Short operation queue between the front end and the back end
module ssr_queue import ssr_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  op_t  push_op_i,
  output logic full_o,
  input  logic pop_i,
  output op_t  head_o,
  output logic empty_o
);

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);

  op_t              entry_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [PTR_W:0]   count_q, count_d;
  logic             do_push;
  logic             do_pop;

  assign full_o  = (count_q == (PTR_W+1)'(QUEUE_DEPTH));
  assign empty_o = (count_q == '0);
  assign head_o  = entry_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    case ({do_push, do_pop})
      2'b10:   count_d = count_q + (PTR_W+1)'(1);
      2'b01:   count_d = count_q - (PTR_W+1)'(1);
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= push_op_i;
    end
  end

endmodule

// File: rtl/ssr_back.sv
// Back end: expands queued operations into output bytes behind an output register
module ssr_back import ssr_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cfg_t      cfg_i,
  input  logic      q_empty_i,
  input  op_t       q_head_i,
  output logic      pop_o,
  output logic      out_valid_o,
  output out_item_t out_data_o,
  input  logic      out_stall_i
);

  typedef enum logic [1:0] {
    BE_IDLE   = 2'b01,
    BE_EXPAND = 2'b10
  } be_state_e;

  be_state_e        state_q, state_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic             out_valid_q, out_valid_d;
  out_item_t        out_q, out_d;

  logic             load_en;
  logic [IDX_W-1:0] lane_idx;
  logic [BYTE_W-1:0] lane_byte;
  logic             lane_final;
  logic             emit;
  out_item_t        item;

  assign load_en    = !out_valid_q || !out_stall_i;
  assign lane_idx   = (state_q == BE_EXPAND) ? idx_q : '0;
  assign lane_byte  = cfg_i.replacement_bytes[BYTE_W*lane_idx +: BYTE_W];
  assign lane_final = ((LEN_W'(lane_idx) + LEN_W'(1)) == cfg_i.replacement_len);

  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    pop_o   = 1'b0;
    emit    = 1'b0;
    item.out_byte    = lane_byte;
    item.last_of_run = q_head_i.last && lane_final;
    item.stream_done = q_head_i.done && lane_final;
    case (state_q)
      BE_IDLE: begin
        if (!q_empty_i) begin
          if (q_head_i.kind == OP_LITERAL) begin
            item.out_byte    = q_head_i.value;
            item.last_of_run = q_head_i.last;
            item.stream_done = q_head_i.done;
            if (load_en) begin
              emit  = 1'b1;
              pop_o = 1'b1;
            end
          end else if (cfg_i.replacement_len == '0) begin
            pop_o = 1'b1;
          end else if (load_en) begin
            emit = 1'b1;
            if (lane_final) begin
              pop_o = 1'b1;
            end else begin
              idx_d   = IDX_W'(1);
              state_d = BE_EXPAND;
            end
          end
        end
      end
      BE_EXPAND: begin
        if (load_en) begin
          emit = 1'b1;
          if (lane_final) begin
            pop_o   = 1'b1;
            state_d = BE_IDLE;
          end else begin
            idx_d = idx_q + IDX_W'(1);
          end
        end
      end
      default: begin
        state_d = BE_IDLE;
      end
    endcase
    out_valid_d = emit || (out_valid_q && out_stall_i);
    out_d       = emit ? item : out_q;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BE_IDLE;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

endmodule

// File: rtl/stream_substring_replace.sv
// Top level of the streaming find-and-replace block
// Usage:
//   Input channel carries one byte per transaction plus an end_of_stream flag;
//   output channel carries one rewritten byte per transaction, with
//   last_of_run on the final byte caused by an input byte and stream_done on
//   the final byte of a stream. Both channels use valid and stall.
//   Registers (pattern, pattern length, replacement, replacement length) are
//   written through the plain write port while the block is idle; a write of
//   the pattern or its length empties the held partial match.
//   Flow: an input byte is taken only while the front end is idle; the front
//   end then pushes one operation per held byte (one for a match), and the
//   input stalls until it is through. The first resulting byte passes the
//   held-byte register, the queue and the output register. The back end
//   drives one byte per cycle while not stalled; at most 8 bytes per item.
//   A four-entry operation queue decouples the two ends.
//   Reset clears all registers to zero (pattern length zero: bytes pass
//   through unchanged) and empties the held bytes and the queue.
//   When the receiver stalls, the output register holds its byte, the queue
//   fills, the front end waits and the input channel stalls.
module stream_substring_replace import ssr_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  in_item_t             in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output out_item_t            out_data_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [WORD_W-1:0]    cfg_data_i
);

  logic [WORD_W-1:0] pattern_q;
  logic [LEN_W-1:0]  plen_q;
  logic [WORD_W-1:0] repl_q;
  logic [LEN_W-1:0]  rlen_q;
  cfg_t              cfg;
  logic              cfg_clear;
  logic              in_ready;
  logic              push;
  op_t               push_op;
  logic              q_full;
  logic              q_empty;
  op_t               q_head;
  logic              pop;

  assign cfg.pattern_bytes     = pattern_q;
  assign cfg.pattern_len       = clamp_len(plen_q);
  assign cfg.replacement_bytes = repl_q;
  assign cfg.replacement_len   = clamp_len(rlen_q);
  assign cfg_clear = cfg_we_i &&
                     ((cfg_idx_i == CFG_PATTERN_BYTES) || (cfg_idx_i == CFG_PATTERN_LEN));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pattern_q <= '0;
      plen_q    <= '0;
      repl_q    <= '0;
      rlen_q    <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_PATTERN_BYTES:     pattern_q <= cfg_data_i;
        CFG_PATTERN_LEN:       plen_q    <= cfg_data_i[LEN_W-1:0];
        CFG_REPLACEMENT_BYTES: repl_q    <= cfg_data_i;
        CFG_REPLACEMENT_LEN:   rlen_q    <= cfg_data_i[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_stall_o = !in_ready;

  ssr_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .cfg_clear_i  (cfg_clear),
    .in_valid_i   (in_valid_i),
    .in_data_i    (in_data_i),
    .in_ready_o   (in_ready),
    .push_o       (push),
    .push_op_o    (push_op),
    .queue_full_i (q_full)
  );

  ssr_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .push_op_i (push_op),
    .full_o    (q_full),
    .pop_i     (pop),
    .head_o    (q_head),
    .empty_o   (q_empty)
  );

  ssr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .q_empty_i   (q_empty),
    .q_head_i    (q_head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .out_stall_i (out_stall_i)
  );

endmodule

// File: rtl/ssr_checker.sv
// Port-level checker of the find-and-replace stream block and its bind
`include "stream_substring_replace_macros.svh"

module ssr_checker import ssr_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_stall_i,
  input logic      out_valid_i,
  input logic      out_stall_i,
  input out_item_t out_data_i
);

  `SSR_ASSERT_SAME(a_done_is_last, out_valid_i && out_data_i.stream_done,
                   out_data_i.last_of_run, "stream_done without last_of_run")

  `SSR_ASSERT_NEXT(a_busy_after_accept, in_valid_i && !in_stall_i, in_stall_i,
                   "input not stalled while a byte is being scanned")

  `SSR_ASSERT_NEXT(a_out_hold, out_valid_i && out_stall_i,
                   out_valid_i && $stable(out_data_i), "stalled output changed")

endmodule

bind stream_substring_replace ssr_checker u_ssr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_i  (in_stall_o),
  .out_valid_i (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_i  (out_data_o)
);
